FILE: hdl/sha1du_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1du_pkg
// Shared types, constants and helpers of the SHA-1 digest unit.
// ----------------------------------------------------------------------------
package sha1du_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int CHAIN_N = 5;
   localparam int SCHED_N = 16;
   localparam int FILL_W  = 6;
   localparam int LEN_W   = 64;
   localparam int IDX_W   = 3;

   // byte source select for the block buffer
   localparam logic [1:0] BSEL_MSG  = 2'd0;
   localparam logic [1:0] BSEL_PAD  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   // round group select (boolean function and constant)
   localparam logic [1:0] GRP_CH   = 2'd0;
   localparam logic [1:0] GRP_PAR1 = 2'd1;
   localparam logic [1:0] GRP_MAJ  = 2'd2;
   localparam logic [1:0] GRP_PAR2 = 2'd3;

   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

   localparam logic [CHAIN_N-1:0][WORD_W-1:0] CHAIN_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [WORD_W-1:0] K_CH   = 32'h5a827999;
   localparam logic [WORD_W-1:0] K_PAR1 = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] K_MAJ  = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] K_PAR2 = 32'hca62c1d6;

   typedef struct packed {
      logic       shift_en;    // push one byte into the block buffer
      logic [1:0] byte_sel;
      logic       count_en;    // message byte: bump the bit count
      logic       load_vars;   // a..e from the chaining words
      logic       round_en;
      logic [1:0] round_grp;
      logic       add_chain;
      logic       rearm;
   } cmd_type;

   typedef struct packed {
      logic blk_last;   // buffer holds 63 bytes
      logic at_56;      // buffer holds 56 bytes
   } status_type;

   function automatic logic [WORD_W-1:0] round_k(input logic [1:0] grp);
      logic [WORD_W-1:0] k;
      unique case (grp)
         GRP_CH:   k = K_CH;
         GRP_PAR1: k = K_PAR1;
         GRP_MAJ:  k = K_MAJ;
         default:  k = K_PAR2;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sha1du_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1du_datapath
// Block buffer and message schedule, round unit, chaining words, bit count.
// ----------------------------------------------------------------------------
module sha1du_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sha1du_pkg::cmd_type           cmd,
   output sha1du_pkg::status_type             sts,
   input  wire logic [7:0]                    msg_byte,
   input  wire logic [2:0]                    word_sel,
   output logic [31:0]                        digest_word
);
   import sha1du_pkg::*;

   logic [SCHED_N-1:0][WORD_W-1:0] blk_ff, blk_in;
   logic [CHAIN_N-1:0][WORD_W-1:0] chain_ff, chain_in;
   logic [WORD_W-1:0]              a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WORD_W-1:0]              a_in, b_in, c_in, d_in, e_in;
   logic [LEN_W-1:0]               len_ff, len_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic [BYTE_W-1:0]              len_byte, byte_mux;
   logic [WORD_W-1:0]              w_cur, w_mix, w_new, f_val, t_sum;

   // length byte by position within the final eight bytes
   always_comb begin
      case (fill_ff[2:0])
         3'd0:    len_byte = len_ff[63:56];
         3'd1:    len_byte = len_ff[55:48];
         3'd2:    len_byte = len_ff[47:40];
         3'd3:    len_byte = len_ff[39:32];
         3'd4:    len_byte = len_ff[31:24];
         3'd5:    len_byte = len_ff[23:16];
         3'd6:    len_byte = len_ff[15:8];
         default: len_byte = len_ff[7:0];
      endcase
   end

   always_comb begin
      unique case (cmd.byte_sel)
         BSEL_MSG:  byte_mux = msg_byte;
         BSEL_PAD:  byte_mux = PAD_BYTE;
         BSEL_ZERO: byte_mux = '0;
         default:   byte_mux = len_byte;
      endcase
   end

   // window holds W[t..t+15], W[t] in the top word
   assign w_cur = blk_ff[SCHED_N-1];
   assign w_mix = blk_ff[SCHED_N-14] ^ blk_ff[SCHED_N-9] ^ blk_ff[SCHED_N-3] ^ w_cur;
   assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

   always_comb begin
      unique case (cmd.round_grp)
         GRP_CH:  f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         GRP_MAJ: f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default: f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_sum = {a_ff[WORD_W-6:0], a_ff[WORD_W-1:WORD_W-5]} + f_val + e_ff
                  + round_k(cmd.round_grp) + w_cur;

   always_comb begin
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      chain_in = chain_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      if (cmd.shift_en) begin
         blk_in  = (SCHED_N*WORD_W)'({blk_ff, byte_mux});
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.count_en) begin
         len_in = len_ff + LEN_W'(BYTE_W);
      end
      if (cmd.load_vars) begin
         a_in = chain_ff[0]; b_in = chain_ff[1]; c_in = chain_ff[2];
         d_in = chain_ff[3]; e_in = chain_ff[4];
      end
      if (cmd.round_en) begin
         blk_in = {blk_ff[SCHED_N-2:0], w_new};
         a_in = t_sum;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[WORD_W-1:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
      if (cmd.add_chain) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
      if (cmd.rearm) begin
         chain_in = CHAIN_INIT;
         len_in   = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= CHAIN_INIT;
         len_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         chain_ff <= chain_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   assign sts.blk_last = (fill_ff == FILL_W'(63));
   assign sts.at_56    = (fill_ff == FILL_W'(56));
   assign digest_word  = chain_ff[word_sel];

endmodule
`default_nettype wire

FILE: hdl/sha1du_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1du_ctrl
// Sequencer: byte intake, padding, 80-round compression and digest readout.
// ----------------------------------------------------------------------------
module sha1du_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_has_byte,
   input  wire logic                 req_end_of_message,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                word_idx,
   output sha1du_pkg::cmd_type       cmd,
   input  wire sha1du_pkg::status_type sts
);
   import sha1du_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_INIT     = 3'd1;
   localparam logic [2:0] ST_ROUND    = 3'd2;
   localparam logic [2:0] ST_ADD      = 3'd3;
   localparam logic [2:0] ST_PAD_ONE  = 3'd4;
   localparam logic [2:0] ST_PAD_ZERO = 3'd5;
   localparam logic [2:0] ST_PAD_LEN  = 3'd6;
   localparam logic [2:0] ST_OUT      = 3'd7;

   localparam logic [6:0] RND_LAST  = 7'd79;
   localparam logic [6:0] RND_PAR1  = 7'd20;
   localparam logic [6:0] RND_MAJ   = 7'd40;
   localparam logic [6:0] RND_PAR2  = 7'd60;
   localparam logic [2:0] IDX_LAST  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic [6:0] rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.byte_sel = BSEL_MSG;
      if (rnd_ff < RND_PAR1) begin
         cmd.round_grp = GRP_CH;
      end else if (rnd_ff < RND_MAJ) begin
         cmd.round_grp = GRP_PAR1;
      end else if (rnd_ff < RND_PAR2) begin
         cmd.round_grp = GRP_MAJ;
      end else begin
         cmd.round_grp = GRP_PAR2;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  cmd.shift_en = 1'b1;
                  cmd.count_en = 1'b1;
               end
               if (req_has_byte && sts.blk_last) begin
                  state_in = ST_INIT;
                  ret_in   = req_end_of_message ? ST_PAD_ONE : ST_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD_ONE;
               end
            end
         end
         ST_PAD_ONE: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_PAD;
            ret_in       = ST_PAD_ZERO;
            state_in     = sts.blk_last ? ST_INIT : ST_PAD_ZERO;
         end
         ST_PAD_ZERO: begin
            if (sts.at_56) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = BSEL_ZERO;
               ret_in       = ST_PAD_ZERO;
               if (sts.blk_last) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_LEN;
            ret_in       = ST_OUT;
            if (sts.blk_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.load_vars = 1'b1;
            rnd_in        = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 1'b1;
            if (rnd_ff == RND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            state_in      = ret_ff;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (idx_ff == IDX_LAST) begin
                  cmd.rearm = 1'b1;
                  idx_in    = '0;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         rnd_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign word_idx  = idx_ff;

endmodule
`default_nettype wire

FILE: hdl/sha1_digest_unit.sv
// A message byte is taken while the unit is idle; a byte that completes a 64-byte block
// starts a compression (load, 80 rounds at one per cycle, chain add).
// End of message: the 0x80 pad byte, zero bytes and the eight length bytes (spilling into
// an extra block when the length does not fit), a compression per block (one or two),
// then five words at one per cycle while rsp_stall is low. No new item is taken until idle.
// Reset (synchronous): chaining words to the initial hash, bit count and fill to zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_digest_unit
// Streaming SHA-1 engine: bytes in, five 32-bit digest words out per message.
// ----------------------------------------------------------------------------
module sha1_digest_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import sha1du_pkg::*;

   cmd_type    cmd;
   status_type sts;
   logic [2:0] word_idx;

   sha1du_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .word_idx           (word_idx),
      .cmd                (cmd),
      .sts                (sts)
   );

   sha1du_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .msg_byte    (req_data_byte),
      .word_sel    (word_idx),
      .digest_word (rsp_digest_word)
   );

   assign rsp_word_index = word_idx;
   assign rsp_last_word  = (word_idx == IDX_W'(CHAIN_N - 1));

endmodule
`default_nettype wire

FILE: hdl/sha1du_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1du_checker
// Port-level checks of the digest unit, bound to the top level.
// ----------------------------------------------------------------------------
module sha1du_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   // no input transfer while the digest is being read out
   a_no_intake_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(req_valid && !req_stall))
      else $error("input accepted during digest readout");

   a_last_marks_fifth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd4)))
      else $error("last_word does not match word index 4");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word_index <= 3'd4))
      else $error("word index out of range");

   // words of one digest follow back to back in order
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word sequence broken");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index)))
      else $error("stalled result changed");

endmodule

bind sha1_digest_unit sha1du_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);
`default_nettype wire

FILE: tb/sha1_digest_unit_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_digest_unit_compare
// Watches both channels of the SHA-1 digest unit. Every accepted byte item is
// fed through a local SHA-1 engine (block gather, padding, length, 80 rounds).
// Each end of message queues five digest words. Every accepted output word is
// checked field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module sha1_digest_unit_compare (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_end_of_message,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_digest_word,
   input  wire logic [2:0]  rsp_word_index,
   input  wire logic        rsp_last_word,
   output int               mismatch_count,
   output int               words_pending
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   localparam logic [4:0][31:0] HASH_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };
   localparam logic [31:0] K_ROUND0 = 32'h5a827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;
   localparam logic [7:0]  PAD_MARK = 8'h80;

   logic [31:0]      chain [5];
   logic [63:0]      msg_bits;
   logic [7:0]       blk [64];
   int               fill;
   digest_entry_type digest_q [$];

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      for (int r = 0; r < 16; r++)
         w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
         // schedule expansion in place over a 16-word window
         if (r >= 16)
            w[r%16] = rotl(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         tmp = rotl(a, 5) + f + e + k + w[r%16];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endtask

   task automatic rearm();
      for (int i = 0; i < 5; i++)
         chain[i] = HASH_INIT[i];
      msg_bits = '0;
      fill = 0;
   endtask

   task automatic absorb_item(input logic [7:0] data, input logic has, input logic eom);
      digest_entry_type ent;
      if (has) begin
         blk[fill] = data;
         fill++;
         msg_bits += 64'd8;
         if (fill == 64) begin
            compress_block();
            fill = 0;
         end
      end
      if (eom) begin
         blk[fill] = PAD_MARK;
         fill++;
         // no room for the length field: pad out and spill into an extra block
         if (fill > 56) begin
            while (fill < 64) begin
               blk[fill] = 8'h00;
               fill++;
            end
            compress_block();
            fill = 0;
         end
         while (fill < 56) begin
            blk[fill] = 8'h00;
            fill++;
         end
         for (int i = 0; i < 8; i++)
            blk[56+i] = msg_bits[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 5; i++) begin
            ent.word  = chain[i];
            ent.index = 3'(i);
            ent.last  = (i == 4);
            digest_q = {digest_q, ent};
         end
         rearm();
      end
   endtask

   task automatic check_word();
      digest_entry_type want;
      if (digest_q.size() == 0) begin
         $display("%0t: digest word expected none got %h index %0d last %0b", $time,
                  rsp_digest_word, rsp_word_index, rsp_last_word);
         mismatch_count++;
      end else begin
         want = digest_q.pop_front();
         if (rsp_digest_word !== want.word) begin
            $display("%0t: digest word %0d expected %h got %h", $time, want.index,
                     want.word, rsp_digest_word);
            mismatch_count++;
         end
         if (rsp_word_index !== want.index) begin
            $display("%0t: word index expected %0d got %0d", $time, want.index,
                     rsp_word_index);
            mismatch_count++;
         end
         if (rsp_last_word !== want.last) begin
            $display("%0t: last flag on word %0d expected %0b got %0b", $time,
                     want.index, want.last, rsp_last_word);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rearm();
         digest_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_word();
         if (req_valid && !req_stall)
            absorb_item(req_data_byte, req_has_byte, req_end_of_message);
      end
      words_pending = digest_q.size();
   end

endmodule

FILE: tb/sha1_digest_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_digest_unit_test
// Drives byte streams into the SHA-1 digest unit: a few short directed
// messages, then random messages, some around the padding boundaries, with random
// idling on both sides and one long output hold. Checking is done beside the
// block; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module sha1_digest_unit_test;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 300;
   localparam int RANDOM_ITEMS   = 300;
   localparam int MIN_MESSAGES   = 12;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   int mismatch_count;
   int words_pending;
   int send_idle_pct = 37;
   int recv_idle_pct = 67;
   int items_sent    = 0;
   int messages_sent = 0;
   int quiet_cycles  = 0;
   bit hold_pending  = 1'b0;
   bit hold_done     = 1'b0;

   sha1_digest_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   sha1_digest_unit_compare digest_compare (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .mismatch_count     (mismatch_count),
      .words_pending      (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // output side: random stall, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
      @(negedge clock);
      if (items_sent < RANDOM_ITEMS / 3) begin
         send_idle_pct = 37;
         recv_idle_pct = 67;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
         send_idle_pct = 67;
         recv_idle_pct = 37;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_has_byte       <= has;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_stall);
      if (has || eom)
         items_sent++;
   endtask

   // in the last phase, hold the output off so the digest backs up into the input
   task automatic arm_long_hold();
      if (items_sent >= 2 * RANDOM_ITEMS / 3 && !hold_done) begin
         hold_pending = 1'b1;
         hold_done = 1'b1;
      end
   endtask

   task automatic send_random_message();
      int  len;
      int  pick;
      bit  bare_end;
      pick = $urandom_range(9);
      if (pick < 6) begin
         len = $urandom_range(20);
      end else if (pick < 8) begin
         // lengths around the point where the length field no longer fits
         case ($urandom_range(5))
            0:       len = 55;
            1:       len = 56;
            2:       len = 57;
            3:       len = 63;
            4:       len = 64;
            default: len = 65;
         endcase
      end else if (pick == 8) begin
         len = $urandom_range(70, 21);
      end else begin
         case ($urandom_range(3))
            0:       len = 119;
            1:       len = 120;
            2:       len = 127;
            default: len = 128;
         endcase
      end
      bare_end = (len == 0) || ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0)
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         if (i == len - 1 && !bare_end)
            arm_long_hold();
         send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !bare_end);
      end
      if (bare_end) begin
         arm_long_hold();
         send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      end
      messages_sent++;
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data_byte      = 8'h00;
      req_has_byte       = 1'b0;
      req_end_of_message = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty message
      send_item(8'hff, 1'b0, 1'b1);
      // no-op item, then empty message again
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // "abc" with the end flag on the last byte
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // "abc" closed by a bare end marker
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      // single-byte extremes
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      // data byte on no-byte items must be ignored
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'haa, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h3c, 1'b0, 1'b1);

      items_sent = 0;
      messages_sent = 0;
      while (items_sent < RANDOM_ITEMS || messages_sent < MIN_MESSAGES)
         send_random_message();

      @(negedge clock);
      req_valid <= 1'b0;
      wait (words_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
